// ----- hw/rtl/lmtsr_pkg.sv -----
// shared types and constants for the scanline renderer
`timescale 1ns / 1ps
`default_nettype none
package lmtsr_pkg;

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_VRAM = 2'd1;
   localparam logic [1:0] CMD_OAM  = 2'd2;

   localparam logic [1:0] MODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_SEARCH = 2'd2;
   localparam logic [1:0] MODE_XFER   = 2'd3;

   localparam logic [2:0] CSR_MAP_HIGH  = 3'd0;
   localparam logic [2:0] CSR_DATA_UNS  = 3'd1;
   localparam logic [2:0] CSR_SCROLL_X  = 3'd2;
   localparam logic [2:0] CSR_SCROLL_Y  = 3'd3;
   localparam logic [2:0] CSR_BG_PAL    = 3'd4;
   localparam logic [2:0] CSR_OBJ_PAL0  = 3'd5;
   localparam logic [2:0] CSR_OBJ_PAL1  = 3'd6;

   localparam logic [16:0] CYC_SEARCH = 17'd80;
   localparam logic [16:0] CYC_XFER   = 17'd172;
   localparam logic [16:0] CYC_HBLANK = 17'd204;
   localparam logic [16:0] CYC_LINE   = 17'd456;

   localparam logic [12:0] MAP_LOW  = 13'h1800;
   localparam logic [12:0] MAP_HIGH = 13'h1c00;
   localparam int MAX_GROUPS = 20;

   typedef struct packed {
      logic [1:0]  command;
      logic [12:0] address;
      logic [7:0]  data;
      logic [15:0] tick_count;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  mode;
      logic [7:0]  line;
      logic [4:0]  group;
      logic [15:0] shades;
      logic        last;
   } rsp_type;

endpackage
`default_nettype wire

// ----- hw/rtl/lcd_mode_timing_scanline_renderer_core.sv -----
// lcd mode timing and scanline renderer top level
// req channel carries ticks, video RAM byte writes and sprite table byte writes.
// rsp channel returns a status item after each tick; a tick that ends the
// transfer mode is followed by min(SCREEN_WIDTH/8, 20) pixel group items,
// last marked. csr port writes the seven display registers; the user must
// do so only while the block is idle, and the block does not enforce it.
// writes are taken in idle; a tick without rendering passes through the
// status state, and req stays stalled until the status item is taken.
// a rendering tick walks the background one pixel at a time (map byte, then
// two tile bytes from the single video RAM port, states BMAP, BLO, BHI, BPUT)
// and then each sprite (four table reads and one check, then per pixel two
// tile reads, a background colour read and a shade buffer write). each group
// of eight shades is gathered from the shade buffer and then sent; the send
// waits while the previous item is still stalled.
// after reset a clearing pass zeroes all 8192 video RAM bytes and the sprite
// table; no item is accepted during it. a stalled rsp holds its item and the
// block waits; req stays stalled until the whole item is delivered.
`timescale 1ns / 1ps
`default_nettype none
module lcd_mode_timing_scanline_renderer_core
   import lmtsr_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 160,
   parameter int SPRITE_COUNT  = 40,
   parameter int VISIBLE_LINES = 144,
   parameter int TOTAL_LINES   = 154
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   input  wire logic    csr_write,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   localparam int GROUPS_RAW = SCREEN_WIDTH / 8;
   localparam int GROUPS = (GROUPS_RAW > MAX_GROUPS) ? MAX_GROUPS : GROUPS_RAW;
   localparam int DRAW_W = GROUPS * 8;
   localparam int SW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
   localparam int LW = $clog2(DRAW_W);

   typedef enum logic [15:0] {
      ST_CLEAR  = 16'h0001,
      ST_IDLE   = 16'h0002,
      ST_STATUS = 16'h0004,
      ST_BMAP   = 16'h0008,
      ST_BLO    = 16'h0010,
      ST_BHI    = 16'h0020,
      ST_BPUT   = 16'h0040,
      ST_SREAD  = 16'h0080,
      ST_SEVAL  = 16'h0100,
      ST_PLO    = 16'h0200,
      ST_PHI    = 16'h0400,
      ST_PRD    = 16'h0800,
      ST_PPUT   = 16'h1000,
      ST_GRD    = 16'h2000,
      ST_GOUT   = 16'h4000,
      ST_SNEXT  = 16'h8000
   } state_type;

   logic [7:0] vram [8192];
   logic [7:0] oam [160];
   logic [1:0] bgl [DRAW_W];
   logic [1:0] shd [DRAW_W];

   state_type   state_ff, state_in;
   logic [12:0] clr_ff, clr_in;
   logic        map_high_ff, data_uns_ff;
   logic [7:0]  scx_ff, scy_ff, bgp_ff, obp0_ff, obp1_ff;
   logic [1:0]  mode_ff, mode_in;
   logic [7:0]  line_ff, line_in, dline_ff, dline_in;
   logic [15:0] acc_ff, acc_in, prev_ff, prev_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        render_ff, render_in;
   logic [8:0]  px_ff, px_in;
   logic [4:0]  col_ff, col_in;
   logic [2:0]  fx_ff, fx_in;
   logic [8:0]  tile_ff, tile_in;
   logic [7:0]  lo_ff, lo_in;
   logic [SW:0] spr_ff, spr_in;
   logic [1:0]  sb_ff, sb_in;
   logic [7:0]  sy_ff, sx_ff, st_ff, sf_ff;
   logic [7:0]  sy_in, sx_in, st_in, sf_in;
   logic [2:0]  trow_ff, trow_in;
   logic [3:0]  k_ff, k_in;
   logic [4:0]  grp_ff, grp_in;
   logic [3:0]  gk_ff, gk_in;
   logic [15:0] gs_ff, gs_in;

   // memory ports
   logic        vwe, owe, bwe, swe;
   logic [12:0] vwa, vra;
   logic [7:0]  vwd, vrd_ff, ord_ff;
   logic [7:0]  owa, ora;
   logic [7:0]  owd;
   logic [LW-1:0] bwa, bra, swa, sra;
   logic [1:0]  bwd, swd, brd_ff, srd_ff;

   always_ff @(posedge clock) begin
      if (vwe) vram[vwa] <= vwd;
      vrd_ff <= vram[vra];
      if (owe) oam[owa] <= owd;
      // sprite entries past the table read as zero
      ord_ff <= (ora < 8'd160) ? oam[ora] : '0;
      if (bwe) bgl[bwa] <= bwd;
      brd_ff <= bgl[bra];
      if (swe) shd[swa] <= swd;
      srd_ff <= shd[sra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_high_ff <= 1'b0; data_uns_ff <= 1'b1;
         scx_ff <= '0; scy_ff <= '0; bgp_ff <= '0; obp0_ff <= '0; obp1_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MAP_HIGH: map_high_ff <= csr_wdata[0];
            CSR_DATA_UNS: data_uns_ff <= csr_wdata[0];
            CSR_SCROLL_X: scx_ff <= csr_wdata;
            CSR_SCROLL_Y: scy_ff <= csr_wdata;
            CSR_BG_PAL:   bgp_ff <= csr_wdata;
            CSR_OBJ_PAL0: obp0_ff <= csr_wdata;
            CSR_OBJ_PAL1: obp1_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   function automatic logic [1:0] pick(input logic [7:0] p, input logic [1:0] c);
      return p[{c, 1'b0} +: 2];
   endfunction

   function automatic logic [12:0] taddr(input logic [8:0] t, input logic [2:0] r);
      return {t, r, 1'b0};
   endfunction

   logic [16:0] sum;
   logic [15:0] acc_sat;
   logic [7:0]  ly;
   logic [12:0] map_base;
   logic [8:0]  nline;
   logic [8:0]  dy;
   logic        hit;
   logic [2:0]  bitsel;
   logic [1:0]  cnum;
   logic [8:0]  ppx;
   logic [2:0]  kk;

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff; clr_in = clr_ff;
      mode_in = mode_ff; line_in = line_ff; dline_in = dline_ff;
      acc_in = acc_ff; prev_in = prev_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall; rsp_in = rsp_ff;
      render_in = render_ff; px_in = px_ff; col_in = col_ff; fx_in = fx_ff;
      tile_in = tile_ff; lo_in = lo_ff; spr_in = spr_ff; sb_in = sb_ff;
      sy_in = sy_ff; sx_in = sx_ff; st_in = st_ff; sf_in = sf_ff;
      trow_in = trow_ff; k_in = k_ff;
      grp_in = grp_ff; gk_in = gk_ff; gs_in = gs_ff;
      vwe = 1'b0; vwa = req_data.address; vwd = req_data.data; vra = '0;
      owe = 1'b0; owa = req_data.address[7:0]; owd = req_data.data; ora = '0;
      bwe = 1'b0; bwa = '0; bwd = '0; bra = '0;
      swe = 1'b0; swa = '0; swd = '0; sra = '0;
      sum = {1'b0, acc_ff} + {1'b0, req_data.tick_count - prev_ff};
      acc_sat = sum[16] ? 16'hffff : sum[15:0];
      ly = line_ff + scy_ff;
      map_base = (map_high_ff ? MAP_HIGH : MAP_LOW) + {3'd0, ly[7:3], 5'd0};
      nline = {1'b0, line_ff} + 9'd1;
      dy = {1'b0, dline_ff} - ({1'b0, sy_ff} - 9'd16);
      hit = (dy < 9'd8);
      kk = k_ff[2:0];
      bitsel = 3'd7 - ((state_ff == ST_PHI && sf_ff[5]) ? 3'd7 - kk :
                       (state_ff == ST_PHI) ? kk : fx_ff);
      cnum = {vrd_ff[bitsel], lo_ff[bitsel]};
      ppx = {1'b0, sx_ff} + {6'd0, kk} - 9'd8;
      case (state_ff)
         ST_CLEAR: begin
            vwe = 1'b1; vwa = clr_ff; vwd = '0;
            owe = (clr_ff < 13'd160); owa = clr_ff[7:0]; owd = '0;
            clr_in = clr_ff + 13'd1;
            if (clr_ff == 13'h1fff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               case (req_data.command)
                  CMD_VRAM: vwe = 1'b1;
                  CMD_OAM: owe = (req_data.address < 13'd160);
                  CMD_TICK: begin
                     prev_in = req_data.tick_count;
                     acc_in = acc_sat;
                     render_in = 1'b0;
                     dline_in = line_ff;
                     case (mode_ff)
                        MODE_HBLANK: if ({1'b0, acc_sat} >= CYC_HBLANK) begin
                           line_in = nline[7:0];
                           mode_in = (nline == 9'(VISIBLE_LINES)) ? MODE_VBLANK
                                                                    : MODE_SEARCH;
                           acc_in = 16'({1'b0, acc_sat} - CYC_HBLANK);
                        end
                        MODE_VBLANK: if ({1'b0, acc_sat} >= CYC_LINE) begin
                           if (nline >= 9'(TOTAL_LINES)) begin
                              line_in = '0; mode_in = MODE_SEARCH;
                           end else line_in = nline[7:0];
                           acc_in = 16'({1'b0, acc_sat} - CYC_LINE);
                        end
                        MODE_SEARCH: if ({1'b0, acc_sat} >= CYC_SEARCH) begin
                           mode_in = MODE_XFER;
                           acc_in = 16'({1'b0, acc_sat} - CYC_SEARCH);
                        end
                        default: if ({1'b0, acc_sat} >= CYC_XFER) begin
                           mode_in = MODE_HBLANK; render_in = 1'b1;
                           acc_in = 16'({1'b0, acc_sat} - CYC_XFER);
                        end
                     endcase
                     state_in = ST_STATUS;
                  end
                  default: ;
               endcase
            end
         end
         ST_STATUS: begin
            if (!rsp_valid_in) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{kind: 1'b0, mode: mode_ff, line: line_ff, group: 5'd0,
                          shades: 16'd0, last: !render_ff};
               if (render_ff) begin
                  px_in = '0; col_in = scx_ff[7:3]; fx_in = scx_ff[2:0];
                  state_in = ST_BMAP;
               end else state_in = ST_IDLE;
            end
         end
         ST_BMAP: begin
            vra = map_base + {8'd0, col_ff};
            state_in = ST_BLO;
         end
         ST_BLO: begin
            tile_in = {(!data_uns_ff && !vrd_ff[7]), vrd_ff};
            vra = taddr({(!data_uns_ff && !vrd_ff[7]), vrd_ff}, ly[2:0]);
            state_in = ST_BHI;
         end
         ST_BHI: begin
            lo_in = vrd_ff;
            vra = taddr(tile_ff, ly[2:0]) | 13'd1;
            state_in = ST_BPUT;
         end
         ST_BPUT: begin
            bwe = 1'b1; bwa = px_ff[LW-1:0]; bwd = cnum;
            swe = 1'b1; swa = px_ff[LW-1:0]; swd = pick(bgp_ff, cnum);
            if (fx_ff == 3'd7) col_in = col_ff + 5'd1;
            fx_in = fx_ff + 3'd1;
            px_in = px_ff + 9'd1;
            if (px_ff == 9'(DRAW_W - 1)) begin
               spr_in = '0; sb_in = '0; state_in = ST_SREAD;
               ora = '0;
            end else state_in = ST_BMAP;
         end
         ST_SREAD: begin
            // sprite bytes y, x, tile, flags
            ora = 8'({spr_ff, sb_ff});
            state_in = ST_SEVAL;
         end
         ST_SEVAL: begin
            case (sb_ff)
               2'd0: sy_in = ord_ff;
               2'd1: sx_in = ord_ff;
               2'd2: st_in = ord_ff;
               default: sf_in = ord_ff;
            endcase
            sb_in = sb_ff + 2'd1;
            if (sb_ff == 2'd3) begin
               k_in = '0;
               state_in = ST_SNEXT;
            end else state_in = ST_SREAD;
         end
         ST_SNEXT: begin
            if (k_ff == 4'd0) begin
               trow_in = sf_ff[6] ? 3'd7 - dy[2:0] : dy[2:0];
               if (!hit) k_in = 4'd8;
               else k_in = 4'd0;
               state_in = hit ? ST_PLO : ST_SNEXT;
               if (hit) k_in = 4'd0;
               else begin
                  spr_in = spr_ff + 1'b1;
                  state_in = (spr_ff == (SW+1)'(SPRITE_COUNT - 1)) ? ST_GRD : ST_SREAD;
                  grp_in = '0; gk_in = '0;
               end
            end else begin
               spr_in = spr_ff + 1'b1;
               grp_in = '0; gk_in = '0;
               state_in = (spr_ff == (SW+1)'(SPRITE_COUNT - 1)) ? ST_GRD : ST_SREAD;
            end
         end
         ST_PLO: begin
            vra = taddr({1'b0, st_ff}, trow_ff);
            bra = ppx[LW-1:0];
            state_in = ST_PHI;
         end
         ST_PHI: begin
            lo_in = vrd_ff;
            vra = taddr({1'b0, st_ff}, trow_ff) | 13'd1;
            bra = ppx[LW-1:0];
            state_in = ST_PRD;
         end
         ST_PRD: begin
            vra = taddr({1'b0, st_ff}, trow_ff) | 13'd1;
            bra = ppx[LW-1:0];
            state_in = ST_PPUT;
         end
         ST_PPUT: begin
            bitsel = 3'd7 - (sf_ff[5] ? 3'd7 - kk : kk);
            cnum = {vrd_ff[bitsel], lo_ff[bitsel]};
            if (!ppx[8] && ppx < 9'(DRAW_W) && !(sf_ff[7] && brd_ff != 2'd0)
                && cnum != 2'd0) begin
               swe = 1'b1; swa = ppx[LW-1:0];
               swd = pick(sf_ff[4] ? obp1_ff : obp0_ff, cnum);
            end
            k_in = k_ff + 4'd1;
            if (k_ff == 4'd7) begin
               k_in = 4'd8; state_in = ST_SNEXT;
            end else state_in = ST_PLO;
         end
         ST_GRD: begin
            sra = LW'({grp_ff, gk_ff[2:0]});
            gk_in = gk_ff + 4'd1;
            if (gk_ff != 4'd0) gs_in = {srd_ff, gs_ff[15:2]};
            if (gk_ff == 4'd8) state_in = ST_GOUT;
         end
         ST_GOUT: begin
            if (!rsp_valid_in) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{kind: 1'b1, mode: mode_ff, line: dline_ff, group: grp_ff,
                          shades: gs_ff, last: (grp_ff == 5'(GROUPS - 1))};
               grp_in = grp_ff + 5'd1; gk_in = '0;
               state_in = (grp_ff == 5'(GROUPS - 1)) ? ST_IDLE : ST_GRD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0;
         mode_ff <= MODE_SEARCH; line_ff <= '0; acc_ff <= '0; prev_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in;
         mode_ff <= mode_in; line_ff <= line_in; acc_ff <= acc_in; prev_ff <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in; dline_ff <= dline_in; render_ff <= render_in;
      px_ff <= px_in; col_ff <= col_in; fx_ff <= fx_in; tile_ff <= tile_in;
      lo_ff <= lo_in; spr_ff <= spr_in; sb_ff <= sb_in;
      sy_ff <= sy_in; sx_ff <= sx_in; st_ff <= st_in; sf_ff <= sf_in;
      trow_ff <= trow_in; k_ff <= k_in;
      grp_ff <= grp_in; gk_ff <= gk_in; gs_ff <= gs_in;
   end

`ifndef NO_ASSERTIONS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("req taken while busy");
   a_mode_after_render: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_GOUT |-> mode_ff == MODE_HBLANK)
      else $error("pixel groups outside hblank");
`endif

endmodule
`default_nettype wire

// ----- dv/lcd_mode_timing_scanline_renderer_core_tb.sv -----
// testbench for the lcd mode timing and scanline renderer core
`timescale 1ns / 1ps
`default_nettype none
module lcd_mode_timing_scanline_renderer_core_tb;
   import lmtsr_pkg::*;

   localparam int WIDTH_PX   = 160;
   localparam int SPRITES    = 40;
   localparam int VIS_LINES  = 144;
   localparam int ALL_LINES  = 154;
   localparam int GROUPS     = WIDTH_PX / 8;

   class display_scoreboard;
      bit [7:0] vram [8192];
      bit [7:0] oam [160];
      bit [1:0] bg_color [WIDTH_PX];
      bit [1:0] shade [WIDTH_PX];
      int mode, line, accum, last_tick;
      int map_high, data_uns, scx, scy, bgp, obp0, obp1;
      rsp_type pending_q[$];
      int errors, n_items, n_results, n_renders;
      bit frame_wrapped;

      function new();
         mode = MODE_SEARCH;
         data_uns = 1;
      endfunction

      function void set_reg(logic [2:0] idx, logic [7:0] v);
         case (idx)
            CSR_MAP_HIGH: map_high = v[0];
            CSR_DATA_UNS: data_uns = v[0];
            CSR_SCROLL_X: scx = v;
            CSR_SCROLL_Y: scy = v;
            CSR_BG_PAL:   bgp = v;
            CSR_OBJ_PAL0: obp0 = v;
            CSR_OBJ_PAL1: obp1 = v;
            default: ;
         endcase
      endfunction

      function int tile_px(int tile, int row, int col);
         int a, b;
         a = ((tile & 511) * 16 + (row & 7) * 2) & 'h1ffe;
         b = 7 - (col & 7);
         return vram[a][b] | (vram[(a + 1) & 'h1fff][b] << 1);
      endfunction

      function void render_line();
         int base, y, col, x, t, c, sy, sx, fl, pal, trow, px;
         base = map_high ? int'(MAP_HIGH) : int'(MAP_LOW);
         base += (((line + scy) & 255) >> 3) << 5;
         y = (line + scy) & 7;
         col = (scx >> 3) & 31;
         x = scx & 7;
         for (int i = 0; i < WIDTH_PX; i++) begin
            t = vram[(base + col) & 'h1fff];
            if (!data_uns && t < 128) t += 256;
            c = tile_px(t, y, x);
            bg_color[i] = 2'(c);
            shade[i] = 2'((bgp >> (c * 2)) & 3);
            if (x == 7) begin
               x = 0;
               col = (col + 1) & 31;
            end else begin
               x++;
            end
         end
         for (int s = 0; s < SPRITES; s++) begin
            sy = int'(oam[s * 4]) - 16;
            sx = int'(oam[s * 4 + 1]) - 8;
            t = oam[s * 4 + 2];
            fl = oam[s * 4 + 3];
            pal = fl[4] ? obp1 : obp0;
            if (!(sy <= line && sy + 8 > line)) continue;
            trow = line - sy;
            if (fl[6]) trow = 7 - trow;
            for (int k = 0; k < 8; k++) begin
               px = sx + k;
               if (px < 0 || px >= WIDTH_PX) continue;
               if (fl[7] && bg_color[px] != 0) continue;
               c = tile_px(t, trow, fl[5] ? 7 - k : k);
               if (c != 0) shade[px] = 2'((pal >> (c * 2)) & 3);
            end
         end
      endfunction

      function void note_item(req_type r);
         int acc, drawn;
         bit rendered;
         rsp_type e;
         n_items++;
         if (r.command == CMD_VRAM) begin
            vram[r.address] = r.data;
            return;
         end
         if (r.command == CMD_OAM) begin
            if (r.address < 160) oam[r.address] = r.data;
            return;
         end
         if (r.command != CMD_TICK) return;
         acc = accum + ((int'(r.tick_count) - last_tick) & 'hffff);
         if (acc > 'hffff) acc = 'hffff;
         last_tick = r.tick_count;
         rendered = 0;
         drawn = line;
         case (2'(mode))
            MODE_HBLANK: if (acc >= 204) begin
               line = (line + 1) & 255;
               mode = (line == VIS_LINES) ? MODE_VBLANK : MODE_SEARCH;
               acc -= 204;
            end
            MODE_VBLANK: if (acc >= 456) begin
               line++;
               if (line >= ALL_LINES) begin
                  line = 0;
                  mode = MODE_SEARCH;
                  frame_wrapped = 1;
               end
               acc -= 456;
            end
            MODE_SEARCH: if (acc >= 80) begin
               mode = MODE_XFER;
               acc -= 80;
            end
            default: if (acc >= 172) begin
               render_line();
               rendered = 1;
               n_renders++;
               mode = MODE_HBLANK;
               acc -= 172;
            end
         endcase
         accum = acc;
         e = '0;
         e.mode = 2'(mode);
         e.line = 8'(line);
         e.last = !rendered;
         pending_q.push_back(e);
         if (rendered) begin
            for (int g = 0; g < GROUPS; g++) begin
               e.kind = 1;
               e.line = 8'(drawn);
               e.group = 5'(g);
               for (int k = 0; k < 8; k++) e.shades[2 * k +: 2] = shade[g * 8 + k];
               e.last = (g == GROUPS - 1);
               pending_q.push_back(e);
            end
         end
      endfunction

      function void check(rsp_type a);
         rsp_type e;
         n_results++;
         if (pending_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result kind=%0d mode=%0d line=%0d group=%0d shades=%h last=%0d",
                     $time, a.kind, a.mode, a.line, a.group, a.shades, a.last);
            return;
         end
         e = pending_q.pop_front();
         if (a.kind !== e.kind || a.mode !== e.mode || a.line !== e.line ||
             a.group !== e.group || a.shades !== e.shades || a.last !== e.last) begin
            errors++;
            $display("%0t: mismatch expected kind=%0d mode=%0d line=%0d group=%0d shades=%h last=%0d",
                     $time, e.kind, e.mode, e.line, e.group, e.shades, e.last);
            $display("%0t:          actual   kind=%0d mode=%0d line=%0d group=%0d shades=%h last=%0d",
                     $time, a.kind, a.mode, a.line, a.group, a.shades, a.last);
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_write;
   logic [2:0] csr_index;
   logic [7:0] csr_wdata;

   display_scoreboard sb = new();
   int burst_left;
   int stall_left;
   bit stall_level;

   lcd_mode_timing_scanline_renderer_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_data);
      if (stall_left == 0) begin
         stall_level = ($urandom_range(0, 2) == 0) ? 1'b1 : 1'b0;
         stall_left = stall_level ? $urandom_range(1, 8) : $urandom_range(1, 60);
      end else begin
         stall_left--;
      end
      rsp_stall <= stall_level;
   end

   task automatic send_item(req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sb.note_item(r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic program_regs(bit [7:0] v [7]);
      for (int i = 0; i < 7; i++) begin
         csr_write <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= v[i];
         @(posedge clock);
         sb.set_reg(3'(i), v[i]);
      end
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_item(logic [1:0] cmd, int addr, int dat, int tick);
      req_type r;
      r.command = cmd;
      r.address = 13'(addr);
      r.data = 8'(dat);
      r.tick_count = 16'(tick);
      return r;
   endfunction

   task automatic send_tick(int delta);
      send_item(make_item(CMD_TICK, $urandom_range(0, 8191), $urandom_range(0, 255),
                          sb.last_tick + delta));
   endtask

   task automatic send_random();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         send_tick($urandom_range(0, 9) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 600));
      end else if (pick < 70) begin
         send_item(make_item(CMD_VRAM, $urandom_range(0, 1) ? $urandom_range('h1800, 'h1fff)
                             : $urandom_range(0, 8191), $urandom_range(0, 255),
                             $urandom_range(0, 65535)));
      end else if (pick < 95) begin
         send_item(make_item(CMD_OAM, $urandom_range(0, 7) != 0 ? $urandom_range(0, 159)
                             : $urandom_range(0, 8191), $urandom_range(0, 255),
                             $urandom_range(0, 65535)));
      end else begin
         send_item(make_item(2'd3, $urandom_range(0, 8191), $urandom_range(0, 255),
                             $urandom_range(0, 65535)));
      end
   endtask

   initial begin
      bit [7:0] regs [7];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      regs = '{8'd1, 8'd0, 8'd3, 8'd5, 8'he4, 8'h1b, 8'hd2};
      program_regs(regs);
      // background tile below 128 in signed mode, sprites with every flag
      send_item(make_item(CMD_VRAM, 'h1c00, 'h05, 0));
      send_item(make_item(CMD_VRAM, 'h105a, 'hff, 0));
      send_item(make_item(CMD_VRAM, 'h105b, 'h0f, 0));
      send_item(make_item(CMD_VRAM, 0, 'hff, 'hffff));
      send_item(make_item(CMD_VRAM, 1, 'haa, 0));
      send_item(make_item(CMD_VRAM, 14, 'h81, 0));
      send_item(make_item(CMD_VRAM, 15, 'h7e, 0));
      send_item(make_item(CMD_VRAM, 8191, 'h00, 0));
      send_item(make_item(CMD_OAM, 0, 16, 0));
      send_item(make_item(CMD_OAM, 1, 8, 0));
      send_item(make_item(CMD_OAM, 3, 'h80, 0));
      send_item(make_item(CMD_OAM, 4, 16, 0));
      send_item(make_item(CMD_OAM, 5, 12, 0));
      send_item(make_item(CMD_OAM, 7, 'h70, 0));
      send_item(make_item(CMD_OAM, 159, 'hff, 0));
      send_item(make_item(CMD_OAM, 8191, 'hff, 0));
      send_item(make_item(2'd3, 8191, 'hff, 'hffff));
      // saturating accumulator, then render of line 0
      send_item(make_item(CMD_TICK, 0, 0, 'hffff));
      send_item(make_item(CMD_TICK, 8191, 'hff, 'hfffe));
      send_item(make_item(CMD_TICK, 0, 0, 0));
      drain();

      regs = '{8'd1, 8'd1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
      program_regs(regs);
      // run of ticks stepping through several lines
      for (int n = 0; n < 60 && !sb.frame_wrapped; n++) begin
         if ($urandom_range(0, 9) == 0) send_random();
         else send_tick($urandom_range(0, 520));
      end
      drain();

      for (int p = 0; p < 4; p++) begin
         if (p == 0) regs = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
         else if (p == 1) regs = '{8'd1, 8'd1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
         else foreach (regs[i]) regs[i] = 8'($urandom_range(0, 255));
         program_regs(regs);
         repeat (25) send_random();
         drain();
      end

      repeat (50) @(posedge clock);
      $display("run covered %0d items, %0d results and %0d rendered lines",
               sb.n_items, sb.n_results, sb.n_renders);
      $display("frame wrap through vertical blank seen: %0d", sb.frame_wrapped);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0t: %0d errors, %0d results never arrived",
                  $time, sb.errors, sb.pending_q.size());
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("%0t: timeout", $time);
      $display("FAILURE");
      $finish;
   end

endmodule
`default_nettype wire
